FILE: hdl/bbs_pkg.sv
// Shared types, codes and reset constants for the battery balance sequencer.
`default_nettype none

package bbs_pkg;

  localparam int unsigned ShortW = 8;
  localparam int unsigned RestW  = 18;
  localparam int unsigned MvW    = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 18;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgWaitReload    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRecheckReload = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgEndReload     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRestDuration  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMinBatteryMv  = 3'd4;

  localparam logic [ShortW-1:0] WaitReloadRst    = 8'd80;
  localparam logic [ShortW-1:0] RecheckReloadRst = 8'd40;
  localparam logic [ShortW-1:0] EndReloadRst     = 8'd24;
  localparam logic [RestW-1:0]  RestDurationRst  = 18'd144000; // 5 h of 1/8 s ticks
  localparam logic [MvW-1:0]    MinBatteryMvRst  = 16'd10100;

  // battery status codes
  localparam logic [2:0] BatStandby     = 3'd0;
  localparam logic [2:0] BatChargeDone  = 3'd1;
  localparam logic [2:0] BatDischarging = 3'd2;

  typedef enum logic [2:0] {
    PH_WAIT_CHARGE = 3'd0,
    PH_RESTING     = 3'd1,
    PH_RECHECK     = 3'd2,
    PH_TOP_UP      = 3'd3,
    PH_END         = 3'd4,
    PH_ABORT       = 3'd5
  } phase_e;

  typedef struct packed {
    logic            start_req;
    logic            leave;
    logic            short_tick;
    logic            long_tick;
    logic [2:0]      battery_status;
    logic            escape_key;
    logic [MvW-1:0]  battery_mv;
    logic            show_charge_info;
  } bbs_in_t;

  typedef struct packed {
    logic [2:0]       phase;
    logic             refresh_ui;
    logic             restore_power;
    logic             break_port;
    logic             second_elapsed;
    logic             finished;
    logic             normal_exit;
    logic [RestW-1:0] rest_remaining;
  } bbs_out_t;

  typedef struct packed {
    logic [ShortW-1:0] wait_reload;
    logic [ShortW-1:0] recheck_reload;
    logic [ShortW-1:0] end_reload;
    logic [RestW-1:0]  rest_duration;
    logic [MvW-1:0]    min_battery_mv;
  } bbs_cfg_t;

  typedef struct packed {
    phase_e            phase;
    logic [ShortW-1:0] short_timer;
    logic [RestW-1:0]  rest_timer;
    logic              view_latch;
    logic              port_broken;
  } bbs_state_t;

endpackage

`default_nettype wire

FILE: hdl/bbs_cfg_regs.sv
// Configuration register file of the battery balance sequencer.
`default_nettype none

module bbs_cfg_regs
  import bbs_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output bbs_cfg_t                 cfg_o
);

  bbs_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgWaitReload:    cfg_d.wait_reload    = cfg_data_i[ShortW-1:0];
        CfgRecheckReload: cfg_d.recheck_reload = cfg_data_i[ShortW-1:0];
        CfgEndReload:     cfg_d.end_reload     = cfg_data_i[ShortW-1:0];
        CfgRestDuration:  cfg_d.rest_duration  = cfg_data_i[RestW-1:0];
        CfgMinBatteryMv:  cfg_d.min_battery_mv = cfg_data_i[MvW-1:0];
        default: ; // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wait_reload    <= WaitReloadRst;
      cfg_q.recheck_reload <= RecheckReloadRst;
      cfg_q.end_reload     <= EndReloadRst;
      cfg_q.rest_duration  <= RestDurationRst;
      cfg_q.min_battery_mv <= MinBatteryMvRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hdl/bbs_step.sv
// Next-state and result logic for one handler call.
`default_nettype none

module bbs_step
  import bbs_pkg::*;
(
  input  wire bbs_in_t    item_i,
  input  wire bbs_cfg_t   cfg_i,
  input  wire bbs_state_t state_i,
  output bbs_state_t      state_o,
  output bbs_out_t        result_o
);

  always_comb begin
    bbs_state_t s;
    logic busy;
    logic refresh, restore, brk, second, fin, normal;

    s       = state_i;
    refresh = 1'b0;
    restore = 1'b0;
    brk     = 1'b0;
    second  = 1'b0;
    fin     = 1'b0;
    normal  = 1'b0;
    busy    = (item_i.battery_status != BatStandby) &&
              (item_i.battery_status != BatChargeDone);

    if (item_i.leave) begin
      s.phase       = PH_ABORT;
      s.short_timer = '0;
      s.rest_timer  = '0;
      s.port_broken = 1'b0;
      restore       = 1'b1;
    end else if (item_i.start_req) begin
      s.port_broken = 1'b0;
      refresh       = 1'b1;
      s.phase       = PH_WAIT_CHARGE;
      s.rest_timer  = cfg_i.rest_duration;
    end else begin
      // saturating tick decrements happen ahead of the phase step
      if (item_i.short_tick && (s.short_timer != '0)) s.short_timer = s.short_timer - 1'b1;
      if (item_i.long_tick && (s.rest_timer != '0)) s.rest_timer = s.rest_timer - 1'b1;

      unique case (state_i.phase)
        PH_WAIT_CHARGE: begin
          if (busy) s.short_timer = cfg_i.wait_reload;
          s.rest_timer = cfg_i.rest_duration;
          if (s.short_timer == '0) begin
            refresh       = 1'b1;
            s.phase       = PH_RESTING;
            restore       = 1'b1;
            brk           = 1'b1;
            s.port_broken = 1'b1;
          end else if (item_i.escape_key || (item_i.battery_status == BatDischarging)) begin
            refresh = 1'b1;
            s.phase = PH_ABORT;
          end else if (item_i.show_charge_info != s.view_latch) begin
            refresh      = 1'b1;
            s.view_latch = item_i.show_charge_info;
          end
        end
        PH_RESTING: begin
          // one second per eight long ticks
          if ((s.rest_timer[2:0] == 3'd0) && !s.view_latch) begin
            refresh      = 1'b1;
            s.view_latch = 1'b1;
            second       = 1'b1;
          end else if (s.rest_timer[2:0] != 3'd0) begin
            s.view_latch = 1'b0;
          end
          if (item_i.escape_key || (item_i.battery_mv < cfg_i.min_battery_mv)) begin
            refresh      = 1'b1;
            s.rest_timer = '0;
            s.phase      = PH_ABORT;
            restore      = 1'b1;
          end else if (s.rest_timer == '0) begin
            refresh       = 1'b1;
            s.phase       = PH_RECHECK;
            s.short_timer = cfg_i.recheck_reload;
            restore       = 1'b1;
          end
        end
        PH_RECHECK: begin
          if ((item_i.battery_status != BatStandby) &&
              (item_i.battery_status != BatDischarging)) s.phase = PH_TOP_UP;
          if (s.short_timer == '0) begin
            refresh       = 1'b1;
            s.phase       = PH_END;
            s.short_timer = cfg_i.end_reload;
          end
        end
        PH_TOP_UP: begin
          s.rest_timer = '0;
          if (busy) s.short_timer = cfg_i.wait_reload;
          if ((s.short_timer == '0) || (item_i.battery_status == BatDischarging)) begin
            refresh       = 1'b1;
            s.phase       = PH_END;
            s.short_timer = cfg_i.end_reload;
          end else if (item_i.escape_key) begin
            refresh = 1'b1;
            s.phase = PH_ABORT;
            restore = 1'b1;
          end else if (item_i.show_charge_info != s.view_latch) begin
            refresh      = 1'b1;
            s.view_latch = item_i.show_charge_info;
          end
        end
        PH_END: begin
          if ((s.short_timer == '0) && (item_i.battery_status == BatStandby)) begin
            fin    = 1'b1;
            normal = 1'b1;
          end
        end
        PH_ABORT: begin
          if (item_i.escape_key) fin = 1'b1;
        end
        default: ; // unreachable codes: phase kept
      endcase

      // closing the cycle returns to idle
      if (fin) begin
        s.phase       = PH_ABORT;
        s.short_timer = '0;
        s.rest_timer  = '0;
        s.port_broken = 1'b0;
        restore       = 1'b1;
      end
    end

    state_o                 = s;
    result_o.phase          = s.phase;
    result_o.refresh_ui     = refresh;
    result_o.restore_power  = restore;
    result_o.break_port     = brk;
    result_o.second_elapsed = second;
    result_o.finished       = fin;
    result_o.normal_exit    = normal;
    result_o.rest_remaining = s.rest_timer;
  end

endmodule

`default_nettype wire

FILE: hdl/battery_balance_sequencer.sv
// Top level of the battery balance sequencer: input register, step logic, result register.
//
// Each input transfer is one handler call of the balancing sequence and yields
// exactly one result transfer. Input and output use valid/ready; a transfer
// happens when valid and ready are both high at a rising clk_i edge.
// Each item passes the input register, then the result register. Throughput:
// one item per cycle while the receiver keeps out_ready_i high; the phase and
// timer state is updated as an item moves from the input register into the
// result register, so the next item sees it with no gap.
// The input register is free to take a new transfer whenever its item can
// move on, so a result waiting on out_ready_i still lets one more item in.
// When the receiver stalls, both registers hold and in_ready_o drops once the
// input register is occupied; no result is lost or repeated.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i at once
// (0 wait reload, 1 recheck reload, 2 end reload, 3 rest duration,
// 4 minimum battery mV); indexes beyond that are ignored. Write only while idle.
// Reset (rst_ni low, asynchronous): pipeline empty, phase abnormal end,
// timers and latches cleared, configuration at its defaults.
`default_nettype none

module battery_balance_sequencer
  import bbs_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire bbs_in_t             in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output bbs_out_t                 out_data_o
);

  bbs_cfg_t   cfg;
  bbs_state_t state_q, state_d;
  bbs_out_t   result;

  logic       in_valid_q;
  bbs_in_t    in_data_q;
  logic       out_valid_q;
  bbs_out_t   out_data_q;
  logic       advance;

  bbs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  bbs_step u_step (
    .item_i   (in_data_q),
    .cfg_i    (cfg),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result)
  );

  // item in the input register moves on when the result slot is free or drains
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q.phase       <= PH_ABORT;
      state_q.short_timer <= '0;
      state_q.rest_timer  <= '0;
      state_q.view_latch  <= 1'b0;
      state_q.port_broken <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_data_q <= in_data_i;
    if (advance) out_data_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

FILE: verif/battery_balance_sequencer_tb.sv
// Testbench for battery_balance_sequencer: self-checking sequencing model, random valid/ready traffic.
`timescale 1ns / 100ps

import bbs_pkg::*;

// Scoreboard: keeps its own copy of the sequencer state and configuration,
// predicts the result of every input transfer and checks results in order.
class balance_scoreboard;
  bbs_cfg_t          cfg;
  phase_e            phase_now;
  logic [ShortW-1:0] short_timer;
  logic [RestW-1:0]  rest_timer;
  bit                view_latch;
  bit                port_broken;
  bbs_out_t          expected_q[$];
  int unsigned       errors;

  function new();
    cfg.wait_reload    = WaitReloadRst;
    cfg.recheck_reload = RecheckReloadRst;
    cfg.end_reload     = EndReloadRst;
    cfg.rest_duration  = RestDurationRst;
    cfg.min_battery_mv = MinBatteryMvRst;
    phase_now   = PH_ABORT;
    short_timer = '0;
    rest_timer  = '0;
    view_latch  = 1'b0;
    port_broken = 1'b0;
    errors      = 0;
  endfunction

  // bits above a register's width are dropped, unknown indexes ignored
  function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    case (idx)
      CfgWaitReload:    cfg.wait_reload    = val[ShortW-1:0];
      CfgRecheckReload: cfg.recheck_reload = val[ShortW-1:0];
      CfgEndReload:     cfg.end_reload     = val[ShortW-1:0];
      CfgRestDuration:  cfg.rest_duration  = val[RestW-1:0];
      CfgMinBatteryMv:  cfg.min_battery_mv = val[MvW-1:0];
      default: ;
    endcase
  endfunction

  // back to abnormal-end idle with the power paths restored
  function void to_idle(inout bbs_out_t r);
    phase_now   = PH_ABORT;
    short_timer = '0;
    rest_timer  = '0;
    port_broken = 1'b0;
    r.restore_power = 1'b1;
  endfunction

  function void note_call(bbs_in_t c);
    bbs_out_t r;
    bit       charging;
    r = '0;
    charging = (c.battery_status != BatStandby) && (c.battery_status != BatChargeDone);
    if (c.leave) begin
      to_idle(r);
    end else if (c.start_req) begin
      port_broken  = 1'b0;
      r.refresh_ui = 1'b1;
      phase_now    = PH_WAIT_CHARGE;
      rest_timer   = cfg.rest_duration;
    end else begin
      // ticks act before the step, saturating at zero
      if (c.short_tick && short_timer != 0) short_timer = short_timer - 1'b1;
      if (c.long_tick && rest_timer != 0) rest_timer = rest_timer - 1'b1;
      case (phase_now)
        PH_WAIT_CHARGE: begin
          if (charging) short_timer = cfg.wait_reload;
          rest_timer = cfg.rest_duration;
          if (short_timer == 0) begin
            // enter the rest: paths reset, then port role switched
            r.refresh_ui    = 1'b1;
            r.restore_power = 1'b1;
            r.break_port    = 1'b1;
            port_broken     = 1'b1;
            phase_now       = PH_RESTING;
          end else if (c.escape_key || c.battery_status == BatDischarging) begin
            r.refresh_ui = 1'b1;
            phase_now    = PH_ABORT;
          end else if (c.show_charge_info != view_latch) begin
            r.refresh_ui = 1'b1;
            view_latch   = c.show_charge_info;
          end
        end
        PH_RESTING: begin
          if (rest_timer[2:0] == 3'd0 && !view_latch) begin
            r.refresh_ui     = 1'b1;
            r.second_elapsed = 1'b1;
            view_latch       = 1'b1;
          end else if (rest_timer[2:0] != 3'd0) begin
            view_latch = 1'b0;
          end
          if (c.escape_key || c.battery_mv < cfg.min_battery_mv) begin
            r.refresh_ui    = 1'b1;
            r.restore_power = 1'b1;
            rest_timer      = '0;
            phase_now       = PH_ABORT;
          end else if (rest_timer == 0) begin
            r.refresh_ui    = 1'b1;
            r.restore_power = 1'b1;
            short_timer     = cfg.recheck_reload;
            phase_now       = PH_RECHECK;
          end
        end
        PH_RECHECK: begin
          if (c.battery_status != BatStandby && c.battery_status != BatDischarging) begin
            phase_now = PH_TOP_UP;
          end
          if (short_timer == 0) begin
            r.refresh_ui = 1'b1;
            short_timer  = cfg.end_reload;
            phase_now    = PH_END;
          end
        end
        PH_TOP_UP: begin
          rest_timer = '0;
          if (charging) short_timer = cfg.wait_reload;
          if (short_timer == 0 || c.battery_status == BatDischarging) begin
            r.refresh_ui = 1'b1;
            short_timer  = cfg.end_reload;
            phase_now    = PH_END;
          end else if (c.escape_key) begin
            r.refresh_ui    = 1'b1;
            r.restore_power = 1'b1;
            phase_now       = PH_ABORT;
          end else if (c.show_charge_info != view_latch) begin
            r.refresh_ui = 1'b1;
            view_latch   = c.show_charge_info;
          end
        end
        PH_END: begin
          if (short_timer == 0 && c.battery_status == BatStandby) begin
            r.finished    = 1'b1;
            r.normal_exit = 1'b1;
            to_idle(r);
          end
        end
        PH_ABORT: begin
          if (c.escape_key) begin
            r.finished = 1'b1;
            to_idle(r);
          end
        end
        default: ;
      endcase
    end
    r.phase          = phase_now;
    r.rest_remaining = rest_timer;
    expected_q.push_back(r);
  endfunction

  function void flag_mismatch(string field, logic [31:0] want, logic [31:0] seen);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, seen);
    errors++;
  endfunction

  function void check_result(bbs_out_t got);
    bbs_out_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, got %h", $time, got);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (got.phase !== want.phase) flag_mismatch("phase", want.phase, got.phase);
    if (got.refresh_ui !== want.refresh_ui) begin
      flag_mismatch("refresh_ui", want.refresh_ui, got.refresh_ui);
    end
    if (got.restore_power !== want.restore_power) begin
      flag_mismatch("restore_power", want.restore_power, got.restore_power);
    end
    if (got.break_port !== want.break_port) begin
      flag_mismatch("break_port", want.break_port, got.break_port);
    end
    if (got.second_elapsed !== want.second_elapsed) begin
      flag_mismatch("second_elapsed", want.second_elapsed, got.second_elapsed);
    end
    if (got.finished !== want.finished) flag_mismatch("finished", want.finished, got.finished);
    if (got.normal_exit !== want.normal_exit) begin
      flag_mismatch("normal_exit", want.normal_exit, got.normal_exit);
    end
    if (got.rest_remaining !== want.rest_remaining) begin
      flag_mismatch("rest_remaining", want.rest_remaining, got.rest_remaining);
    end
  endfunction
endclass

module battery_balance_sequencer_tb;

  localparam int unsigned TimeoutNs     = 1_000_000;
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned SettleCycles  = 6;

  // status codes without a package name
  localparam logic [2:0] BatCharging    = 3'd3;
  localparam logic [2:0] BatChargeError = 3'd4;
  localparam logic [2:0] BatOddCode     = 3'd7;  // treated as charging

  // index with no register behind it
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  bbs_in_t             in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  bbs_out_t            out_data_o;

  balance_scoreboard sb = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_off_req   = 1'b0;

  battery_balance_sequencer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #(TimeoutNs);
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: ready is set at the rising edge, the transfer is decided and
  // checked at the falling edge before the edge that completes it.
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        // long hold-off: the block fills up and must stall its input
        out_ready_i <= 1'b0;
        hold_off_req = 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      @(negedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
    end
  end

  // 0: no idling, 1: sender idles, 2: receiver stalls, 3: both
  task automatic set_idle(input int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
      default: begin send_idle_pct = 26; recv_stall_pct = 26; end
    endcase
  endtask

  // Entered and left right after a rising edge; the item is noted once the
  // transfer has taken place.
  task automatic send_call(input bbs_in_t c);
    bit took;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    sb.note_call(c);
  endtask

  // drop valid, wait for every outstanding result, then let the pipe drain
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // junk above each register's width must be ignored by the block
  task automatic program_regs(input logic [ShortW-1:0] wait_v, recheck_v, end_v,
                              input logic [RestW-1:0] rest_v, input logic [MvW-1:0] mv_v);
    logic [CfgDataW-1:0] junk;
    junk = CfgDataW'($urandom);
    write_reg(CfgWaitReload, {junk[CfgDataW-1:ShortW], wait_v});
    write_reg(CfgRecheckReload, {junk[CfgDataW-1:ShortW], recheck_v});
    write_reg(CfgEndReload, {junk[CfgDataW-1:ShortW], end_v});
    write_reg(CfgRestDuration, rest_v);
    write_reg(CfgMinBatteryMv, {junk[CfgDataW-1:MvW], mv_v});
    write_reg(CfgUnused, junk);
  endtask

  function automatic bbs_in_t handler_call(bit start, bit leave_v, bit st, bit lt,
                                           logic [2:0] bs, bit esc, logic [MvW-1:0] mv,
                                           bit show);
    bbs_in_t c;
    c.start_req        = start;
    c.leave            = leave_v;
    c.short_tick       = st;
    c.long_tick        = lt;
    c.battery_status   = bs;
    c.escape_key       = esc;
    c.battery_mv       = mv;
    c.show_charge_info = show;
    return c;
  endfunction

  // Mostly calls that move the sequence forward from the phase the model is
  // in, with random content; the rest is leave requests and plain noise.
  task automatic run_random(input int unsigned n);
    bbs_in_t     c;
    logic [31:0] noise;
    int unsigned r;
    repeat (n) begin
      noise = $urandom;
      c = noise[$bits(bbs_in_t)-1:0];
      r = $urandom_range(0, 99);
      if (r < 3) begin
        c.leave = 1'b1;
      end else if (r >= 10) begin
        c.start_req  = 1'b0;
        c.leave      = 1'b0;
        c.escape_key = ($urandom_range(0, 99) < 3);
        c.short_tick = ($urandom_range(0, 99) < 75);
        c.long_tick  = ($urandom_range(0, 99) < 85);
        if ($urandom_range(0, 99) < 85) c.show_charge_info = sb.view_latch;
        if ($urandom_range(0, 99) < 95) begin
          c.battery_mv = MvW'($urandom_range(sb.cfg.min_battery_mv, 16'hFFFF));
        end
        case (sb.phase_now)
          PH_WAIT_CHARGE, PH_TOP_UP: begin
            if ($urandom_range(0, 99) < 80) begin
              c.battery_status = $urandom_range(0, 1) ? BatChargeDone : BatStandby;
            end
          end
          PH_END: begin
            if ($urandom_range(0, 99) < 70) c.battery_status = BatStandby;
          end
          PH_ABORT: begin
            c.start_req  = ($urandom_range(0, 99) < 60);
            c.escape_key = ($urandom_range(0, 99) < 25);
          end
          default: ;
        endcase
      end
      send_call(c);
    end
    settle();
  endtask

  initial begin : stimulus
    int unsigned k;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed walk through a full cycle with short timers and a 9-tick rest.
    set_idle(0);
    program_regs(8'd2, 8'd2, 8'd1, 18'd9, 16'd10100);
    send_call(handler_call(0, 0, 0, 0, BatStandby, 1, 16'hFFFF, 0));      // escape while idle
    send_call(handler_call(1, 1, 1, 1, BatOddCode, 1, 16'hFFFF, 1));      // leave beats start
    send_call(handler_call(1, 0, 0, 0, BatStandby, 0, 16'h0000, 0));      // start
    send_call(handler_call(0, 0, 1, 0, BatCharging, 0, 16'd12000, 0));    // still charging
    send_call(handler_call(0, 0, 0, 0, BatOddCode, 0, 16'd12000, 1));     // odd code, view flip
    send_call(handler_call(0, 0, 0, 0, BatDischarging, 0, 16'd12000, 1)); // discharge aborts
    send_call(handler_call(1, 0, 0, 0, BatStandby, 0, 16'd12000, 1));     // restart
    send_call(handler_call(0, 0, 1, 0, BatChargeDone, 0, 16'd12000, 0));
    send_call(handler_call(0, 0, 1, 0, BatStandby, 0, 16'd12000, 0));     // timer out: rest
    repeat (9) send_call(handler_call(0, 0, 0, 1, BatCharging, 0, 16'hFFFF, 1));
    send_call(handler_call(0, 0, 1, 0, BatStandby, 0, 16'd12000, 0));     // recheck
    send_call(handler_call(0, 0, 0, 0, BatChargeError, 0, 16'd12000, 0)); // top-up seen
    send_call(handler_call(0, 0, 1, 0, BatChargeDone, 0, 16'd12000, 0));  // to end
    send_call(handler_call(0, 0, 1, 0, BatStandby, 0, 16'd12000, 0));     // normal finish
    settle();

    // all registers at zero
    set_idle(1);
    program_regs(8'd0, 8'd0, 8'd0, 18'd0, 16'd0);
    run_random(150);

    // short settings so that whole cycles complete often
    for (k = 0; k < 5; k++) begin
      set_idle(k % 4);
      program_regs(ShortW'($urandom_range(1, 6)), ShortW'($urandom_range(1, 6)),
                   ShortW'($urandom_range(0, 4)), RestW'($urandom_range(1, 40)),
                   MvW'($urandom_range(8000, 12000)));
      if (k == 0) hold_off_req = 1'b1;
      run_random(250);
    end

    // all registers at their maximum
    set_idle(3);
    program_regs(8'hFF, 8'hFF, 8'hFF, 18'h3FFFF, 16'hFFFF);
    run_random(150);

    // back to the reset defaults
    set_idle(2);
    program_regs(WaitReloadRst, RecheckReloadRst, EndReloadRst, RestDurationRst,
                 MinBatteryMvRst);
    run_random(100);

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
